[rtl/core/ldfu_pkg.sv]
// Package: shared types and constants for the LED frame deframer.
`timescale 1ns / 1ps

package ldfu_pkg;

    // Default strip length limit
    localparam int unsigned MAX_LEDS_DEF = 256;

    // Configuration register indexes
    localparam logic [1:0] CFG_LED_COUNT = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT   = 2'd1;

    // Frame prefix and check constants
    localparam logic [7:0] PREFIX_0  = 8'h41;   // 'A'
    localparam logic [7:0] PREFIX_1  = 8'h64;   // 'd'
    localparam logic [7:0] PREFIX_2  = 8'h61;   // 'a'
    localparam logic [7:0] CHECK_KEY = 8'h55;

    // Input beat kinds
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Result kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_BLANK = 1'b1;

    // One result beat
    typedef struct packed {
        logic       kind;
        logic [7:0] led_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } t_result;

endpackage

[rtl/core/ldfu_if.sv]
// Interfaces: input and result channels with valid/ready handshake.
`timescale 1ns / 1ps

interface ldfu_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface ldfu_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_end;

    modport source (output valid, output kind, output led_index, output red,
                    output green, output blue, output frame_end, input ready);
    modport sink   (input valid, input kind, input led_index, input red,
                    input green, input blue, input frame_end, output ready);
endinterface

[rtl/core/ldfu_core.sv]
// Core: input register, frame parser, idle timer and configuration registers.
`timescale 1ns / 1ps

module ldfu_core
    import ldfu_pkg::*;
#(
    parameter int unsigned MAX_LEDS = MAX_LEDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ldfu_in_if.sink     i_in_ch,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_out_free,
    output logic        o_emit,
    output t_result     o_result
);

    // Parser phases
    localparam logic [3:0] PH_P0  = 4'd0;
    localparam logic [3:0] PH_P1  = 4'd1;
    localparam logic [3:0] PH_P2  = 4'd2;
    localparam logic [3:0] PH_HI  = 4'd3;
    localparam logic [3:0] PH_LO  = 4'd4;
    localparam logic [3:0] PH_CHK = 4'd5;
    localparam logic [3:0] PH_R   = 4'd6;
    localparam logic [3:0] PH_G   = 4'd7;
    localparam logic [3:0] PH_B   = 4'd8;

    localparam logic [8:0] MaxCount = 9'(MAX_LEDS);

    // Input register
    logic       r_in_valid;
    logic       r_in_mode;
    logic [7:0] r_in_byte;

    // Configuration
    logic [8:0]  r_led_count;
    logic [15:0] r_timeout;

    // Parser and timer state
    logic [3:0]  r_phase,    n_phase;
    logic [7:0]  r_cnt_hi,   n_cnt_hi;
    logic [7:0]  r_cnt_lo,   n_cnt_lo;
    logic [7:0]  r_red,      n_red;
    logic [7:0]  r_green,    n_green;
    logic [7:0]  r_pix,      n_pix;
    logic [15:0] r_idle,     n_idle;
    logic        r_active,   n_active;

    logic        advance;
    logic [8:0]  eff_count;
    logic [8:0]  last_index;
    logic        is_last;

    assign advance        = r_in_valid && i_out_free;
    assign i_in_ch.ready  = !r_in_valid || advance;

    // Clamp the strip length into 1..MAX_LEDS
    always_comb begin
        if (r_led_count == 9'd0) begin
            eff_count = 9'd1;
        end else if (r_led_count > MaxCount) begin
            eff_count = MaxCount;
        end else begin
            eff_count = r_led_count;
        end
        last_index = eff_count - 9'd1;
        is_last    = {1'b0, r_pix} >= last_index;
    end

    // Step the parser or the idle timer for the held beat
    always_comb begin
        n_phase  = r_phase;
        n_cnt_hi = r_cnt_hi;
        n_cnt_lo = r_cnt_lo;
        n_red    = r_red;
        n_green  = r_green;
        n_pix    = r_pix;
        n_idle   = r_idle;
        n_active = r_active;
        o_emit   = 1'b0;
        o_result = '0;

        if (r_in_mode == MODE_TICK) begin
            if (r_idle != 16'hFFFF) begin
                n_idle = r_idle + 16'd1;
            end
            if (r_active && (n_idle >= r_timeout)) begin
                n_active      = 1'b0;
                o_emit        = r_in_valid;
                o_result.kind = KIND_BLANK;
            end
        end else begin
            unique case (r_phase)
                PH_P0:  n_phase = (r_in_byte == PREFIX_0) ? PH_P1 : PH_P0;
                PH_P1:  n_phase = (r_in_byte == PREFIX_1) ? PH_P2 : PH_P0;
                PH_P2:  n_phase = (r_in_byte == PREFIX_2) ? PH_HI : PH_P0;
                PH_HI: begin
                    n_cnt_hi = r_in_byte;
                    n_phase  = PH_LO;
                end
                PH_LO: begin
                    n_cnt_lo = r_in_byte;
                    n_phase  = PH_CHK;
                end
                PH_CHK: begin
                    if (r_in_byte == (r_cnt_hi ^ r_cnt_lo ^ CHECK_KEY)) begin
                        n_pix   = 8'd0;
                        n_phase = PH_R;
                    end else begin
                        n_phase = PH_P0;
                    end
                end
                PH_R: begin
                    n_red   = r_in_byte;
                    n_phase = PH_G;
                end
                PH_G: begin
                    n_green = r_in_byte;
                    n_phase = PH_B;
                end
                PH_B: begin
                    o_emit             = r_in_valid;
                    o_result.kind      = KIND_PIXEL;
                    o_result.led_index = r_pix;
                    o_result.red       = r_red;
                    o_result.green     = r_green;
                    o_result.blue      = r_in_byte;
                    o_result.frame_end = is_last;
                    if (is_last) begin
                        n_phase  = PH_P0;
                        n_pix    = 8'd0;
                        n_idle   = 16'd0;
                        n_active = 1'b1;
                    end else begin
                        n_pix   = r_pix + 8'd1;
                        n_phase = PH_R;
                    end
                end
                default: n_phase = PH_P0;
            endcase
        end
    end

    // Hold the incoming beat until it is processed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_ch.valid && i_in_ch.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_ch.valid && i_in_ch.ready) begin
            r_in_mode <= i_in_ch.mode;
            r_in_byte <= i_in_ch.data_byte;
        end
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_led_count <= 9'd60;
            r_timeout   <= 16'd1000;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_LED_COUNT) begin
                r_led_count <= i_cfg_data[8:0];
            end else if (i_cfg_index == CFG_TIMEOUT) begin
                r_timeout <= i_cfg_data;
            end
        end
    end

    // Advance parser and timer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_P0;
            r_pix    <= 8'd0;
            r_idle   <= 16'd0;
            r_active <= 1'b1;
        end else if (advance) begin
            r_phase  <= n_phase;
            r_pix    <= n_pix;
            r_idle   <= n_idle;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_hi <= 8'd0;
            r_cnt_lo <= 8'd0;
            r_red    <= 8'd0;
            r_green  <= 8'd0;
        end else if (advance) begin
            r_cnt_hi <= n_cnt_hi;
            r_cnt_lo <= n_cnt_lo;
            r_red    <= n_red;
            r_green  <= n_green;
        end
    end

endmodule

[rtl/core/ldfu_out_reg.sv]
// Output register: holds one result beat until the receiver takes it.
`timescale 1ns / 1ps

module ldfu_out_reg
    import ldfu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_result     i_result,
    output logic        o_free,
    ldfu_out_if.source  o_out_ch
);

    logic    r_valid;
    t_result r_data;

    assign o_free = !r_valid || o_out_ch.ready;

    // Track occupancy of the result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Capture a new beat when the slot frees up
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_data <= i_result;
        end
    end

    assign o_out_ch.valid     = r_valid;
    assign o_out_ch.kind      = r_data.kind;
    assign o_out_ch.led_index = r_data.led_index;
    assign o_out_ch.red       = r_data.red;
    assign o_out_ch.green     = r_data.green;
    assign o_out_ch.blue      = r_data.blue;
    assign o_out_ch.frame_end = r_data.frame_end;

endmodule

[rtl/core/led_frame_deframer_unit.sv]
// Top level: serial LED frame deframer with idle-timeout blanking.
//
// Usage:
//   i_in_ch carries one beat per serial byte (mode 0) or per time tick
//   (mode 1). Bytes are parsed as 'A','d','a', count hi, count lo, check,
//   then led_count RGB triples; each blue byte yields one pixel result on
//   o_out_ch, the last one flagged frame_end. A tick that brings the idle
//   count to or past timeout_ticks while the strip is active yields one
//   blank result. Other beats yield nothing.
//   Configuration: pulse i_cfg_we with i_cfg_index (0 led_count, 1
//   timeout_ticks) and i_cfg_data, only while the block is idle.
// Timing:
//   One beat per cycle while the result slot is free. A beat is held in the
//   input register, then stepped through the parser into the result
//   register; a stall on o_out_ch holds it in the input register.
// Reset (synchronous, active low): the parser searches for 'A', counters
//   clear, the strip is active, led_count is 60 and timeout_ticks 1000.
// Stall: while a result waits on o_out_ch the input register still takes
//   one beat; further beats wait until the result slot drains.
`timescale 1ns / 1ps

module led_frame_deframer_unit
    import ldfu_pkg::*;
#(
    parameter int unsigned MAX_LEDS = MAX_LEDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ldfu_in_if.sink     i_in_ch,
    ldfu_out_if.source  o_out_ch,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic    out_free;
    logic    emit;
    t_result result;

    // Parser and timer
    ldfu_core #(
        .MAX_LEDS (MAX_LEDS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_ch     (i_in_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_free  (out_free),
        .o_emit      (emit),
        .o_result    (result)
    );

    // Result register
    ldfu_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (emit),
        .i_result (result),
        .o_free   (out_free),
        .o_out_ch (o_out_ch)
    );

endmodule
